/* rtl/core/ttok_pkg.sv */
// ttok_pkg: shared types and constants for the text tokenizer.
// No dependencies; imported by every ttok module but ttok_checker.
package ttok_pkg;

   // Character classes of a text byte against the two configured sets
   typedef logic [1:0] ttok_cls_type;
   localparam ttok_cls_type CLS_PLAIN   = 2'd0;
   localparam ttok_cls_type CLS_WS      = 2'd1;
   localparam ttok_cls_type CLS_SPECIAL = 2'd2;

   // Configuration register indexes
   typedef logic [0:0] ttok_csr_idx_type;
   localparam ttok_csr_idx_type CSR_WHITESPACE = 1'd0;
   localparam ttok_csr_idx_type CSR_SPECIAL    = 1'd1;

   localparam int unsigned WS_SLOTS   = 4;
   localparam int unsigned SPEC_SLOTS = 8;

   localparam logic [31:0] WS_RESET   = 32'h0D0A_0920;
   localparam logic [63:0] SPEC_RESET = 64'h0;

   // Result kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // One result word (without the run_last flag, set on drain)
   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
      logic       trunc;
   } ttok_res_type;

   // All results caused by one byte: 1..4 entries
   typedef struct packed {
      logic [2:0]              cnt;
      ttok_res_type [3:0]      res;
   } ttok_bundle_type;

endpackage

/* rtl/core/text_tokenizer_stream.sv */
// text_tokenizer_stream: streaming lexer, one text byte per accepted word.
// Each byte passes the input register, then the result register, to rsp_.
// Throughput: one byte per cycle while each byte yields at most one word and
//   rsp_ready is high; a byte of N words holds the result register till all leave.
// Reset (sync, active high): empties both stages, lexer back to normal
//   scanning, whitespace set = space/tab/LF/CR, special set empty.
module text_tokenizer_stream #(
   parameter int unsigned MAX_TOKEN_CHARS = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   // byte input channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_text_byte,
   input  logic                             req_final_byte,
   // result channel: token chars and end-of-token markers
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_out_kind,
   output logic [7:0]                       rsp_out_char,
   output logic                             rsp_token_truncated,
   output logic                             rsp_run_last,
   // register write port
   input  logic                             csr_wr_en,
   input  ttok_pkg::ttok_csr_idx_type       csr_index,
   input  logic [63:0]                      csr_wdata
);
   import ttok_pkg::*;

   // Character set registers: write only while the block is idle; the block does not enforce it.
   logic [31:0]     ws_chars_ff;
   logic [63:0]     spec_chars_ff;

   // Lexer -> result register handoff: up to four words per byte
   logic            bnd_valid;
   logic            bnd_ready;
   ttok_bundle_type bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_chars_ff   <= WS_RESET;
         spec_chars_ff <= SPEC_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WHITESPACE: ws_chars_ff   <= csr_wdata[31:0];
            CSR_SPECIAL:    spec_chars_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // Stage 1: input register + classify + lexer step (state commits when
   // the byte's words are handed to the result register, or at once if the
   // byte yields no words, e.g. inside a comment).
   ttok_lexer #(
      .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
   ) u_lexer (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_byte    (req_text_byte),
      .in_final   (req_final_byte),
      .ws_chars   (ws_chars_ff),
      .spec_chars (spec_chars_ff),
      .bnd_valid  (bnd_valid),
      .bnd_ready  (bnd_ready),
      .bnd        (bnd)
   );

   // Stage 2: result register; drains the bundle one word per handshake and
   // flags the byte's last word. Reloads in the cycle its last word leaves.
   ttok_out u_out (
      .clock               (clock),
      .reset               (reset),
      .bnd_valid           (bnd_valid),
      .bnd_ready           (bnd_ready),
      .bnd                 (bnd),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_kind        (rsp_out_kind),
      .rsp_out_char        (rsp_out_char),
      .rsp_token_truncated (rsp_token_truncated),
      .rsp_run_last        (rsp_run_last)
   );

endmodule

/* rtl/core/ttok_classify.sv */
// ttok_classify: compares one byte against the whitespace and special sets.
// Depends on ttok_pkg.
module ttok_classify (
   input  logic [7:0]             text_byte,
   input  logic [31:0]            ws_chars,
   input  logic [63:0]            spec_chars,
   output ttok_pkg::ttok_cls_type cls
);
   import ttok_pkg::*;

   logic [WS_SLOTS-1:0]   ws_hit;
   logic [SPEC_SLOTS-1:0] spec_hit;

   always_comb begin
      for (int i = 0; i < WS_SLOTS; i++) begin
         ws_hit[i] = (ws_chars[8*i +: 8] == text_byte);
      end
      for (int i = 0; i < SPEC_SLOTS; i++) begin
         spec_hit[i] = (spec_chars[8*i +: 8] == text_byte);
      end
   end

   // byte zero marks an unused slot, so it never matches
   always_comb begin
      priority if (text_byte == 8'd0) begin
         cls = CLS_PLAIN;
      end else if (|ws_hit) begin
         cls = CLS_WS;
      end else if (|spec_hit) begin
         cls = CLS_SPECIAL;
      end else begin
         cls = CLS_PLAIN;
      end
   end

endmodule

/* rtl/core/ttok_lexer.sv */
// ttok_lexer: input register, lexer state and the per-byte result bundle.
// Depends on ttok_pkg and ttok_classify.
module ttok_lexer #(
   parameter int unsigned MAX_TOKEN_CHARS = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [7:0]                in_byte,
   input  logic                      in_final,
   input  logic [31:0]               ws_chars,
   input  logic [63:0]               spec_chars,
   output logic                      bnd_valid,
   input  logic                      bnd_ready,
   output ttok_pkg::ttok_bundle_type bnd
);
   import ttok_pkg::*;

   localparam logic [7:0] MaxLen      = 8'(MAX_TOKEN_CHARS);
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_NL     = 8'h0A;

   localparam logic [1:0] MODE_NORMAL  = 2'd0;
   localparam logic [1:0] MODE_QUOTE   = 2'd1;
   localparam logic [1:0] MODE_COMMENT = 2'd2;
   localparam logic [1:0] MODE_SLASH   = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic [7:0]         tlen;
      logic               ovf;
      ttok_cls_type       scls;
      logic [2:0]         cnt;
      ttok_res_type [3:0] res;
   } work_type;

   logic               in_valid_ff;
   logic [7:0]         byte_ff;
   logic               final_ff;
   logic [1:0]         mode_ff;
   logic [7:0]         tlen_ff;
   logic               ovf_ff;
   ttok_cls_type       scls_ff;
   ttok_cls_type       cls;
   work_type           work;
   logic               advance;

   ttok_classify u_cls (
      .text_byte  (byte_ff),
      .ws_chars   (ws_chars),
      .spec_chars (spec_chars),
      .cls        (cls)
   );

   function automatic work_type emit(work_type w, logic k, logic [7:0] c, logic t);
      work_type r;
      r = w;
      if (r.cnt < 3'd4) begin
         r.res[r.cnt[1:0]] = '{kind: k, ch: c, trunc: t};
         r.cnt = r.cnt + 3'd1;
      end
      return r;
   endfunction

   function automatic work_type end_token(work_type w);
      work_type r;
      r = w;
      if (r.tlen != 8'd0) r = emit(r, KIND_END, 8'd0, r.ovf);
      r.tlen = 8'd0;
      r.ovf  = 1'b0;
      return r;
   endfunction

   function automatic work_type append(work_type w, logic [7:0] b);
      work_type r;
      r = w;
      if (r.tlen < MaxLen) begin
         r = emit(r, KIND_CHAR, b, 1'b0);
         r.tlen = r.tlen + 8'd1;
      end else begin
         r.ovf = 1'b1;
      end
      return r;
   endfunction

   function automatic work_type plain_rules(work_type w, logic [7:0] b, ttok_cls_type c);
      work_type r;
      r = w;
      if (c == CLS_WS) begin
         r = end_token(r);
      end else if (c == CLS_SPECIAL) begin
         r = end_token(r);
         r = emit(r, KIND_CHAR, b, 1'b0);
         r = emit(r, KIND_END, 8'd0, 1'b0);
      end else if (b == CHAR_QUOTE) begin
         r.mode = MODE_QUOTE;
      end else begin
         r = append(r, b);
      end
      return r;
   endfunction

   function automatic work_type normal_byte(work_type w, logic [7:0] b, logic fin,
                                            ttok_cls_type c);
      work_type r;
      r = w;
      if (b == CHAR_SLASH && !fin) begin
         // slash waits one byte for a second slash; its class is latched now
         if (c != CLS_PLAIN) r = end_token(r);
         r.scls = c;
         r.mode = MODE_SLASH;
      end else begin
         r = plain_rules(r, b, c);
      end
      return r;
   endfunction

   always_comb begin
      work      = '0;
      work.mode = mode_ff;
      work.tlen = tlen_ff;
      work.ovf  = ovf_ff;
      work.scls = scls_ff;
      unique case (mode_ff)
         MODE_QUOTE: begin
            if (byte_ff == CHAR_QUOTE) begin
               work      = end_token(work);
               work.mode = MODE_NORMAL;
            end else begin
               work = append(work, byte_ff);
            end
         end
         MODE_COMMENT: begin
            if (byte_ff == CHAR_NL) begin
               work.mode = MODE_NORMAL;
               work      = normal_byte(work, byte_ff, final_ff, cls);
            end
         end
         MODE_SLASH: begin
            if (byte_ff == CHAR_SLASH) begin
               work      = end_token(work);
               work.mode = MODE_COMMENT;
            end else begin
               work.mode = MODE_NORMAL;
               work      = plain_rules(work, CHAR_SLASH, scls_ff);
               work      = normal_byte(work, byte_ff, final_ff, cls);
            end
         end
         default: begin
            work = normal_byte(work, byte_ff, final_ff, cls);
         end
      endcase
      if (final_ff) begin
         work      = end_token(work);
         work.mode = MODE_NORMAL;
         work.scls = CLS_PLAIN;
      end
   end

   assign bnd_valid = in_valid_ff && (work.cnt != 3'd0);
   assign advance   = in_valid_ff && ((work.cnt == 3'd0) || bnd_ready);
   assign in_ready  = !in_valid_ff || advance;
   assign bnd.cnt   = work.cnt;
   assign bnd.res   = work.res;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_NORMAL;
         tlen_ff     <= 8'd0;
         ovf_ff      <= 1'b0;
         scls_ff     <= CLS_PLAIN;
      end else begin
         if (in_ready) in_valid_ff <= in_valid;
         if (advance) begin
            mode_ff <= work.mode;
            tlen_ff <= work.tlen;
            ovf_ff  <= work.ovf;
            scls_ff <= work.scls;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff  <= in_byte;
         final_ff <= in_final;
      end
   end

endmodule

/* rtl/core/ttok_out.sv */
// ttok_out: result register holding one bundle, drained a word a cycle while rsp_ready is high.
// Depends on ttok_pkg.
module ttok_out (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      bnd_valid,
   output logic                      bnd_ready,
   input  ttok_pkg::ttok_bundle_type bnd,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_out_kind,
   output logic [7:0]                rsp_out_char,
   output logic                      rsp_token_truncated,
   output logic                      rsp_run_last
);
   import ttok_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   logic [1:0]      idx_ff;
   logic [1:0]      idx_in;
   ttok_bundle_type bnd_ff;
   logic            pop;
   logic            last;

   assign last      = ({1'b0, idx_ff} == (bnd_ff.cnt - 3'd1));
   assign pop       = valid_ff && rsp_ready;
   assign bnd_ready = !valid_ff || (pop && last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (bnd_ready) begin
         valid_in = bnd_valid;
         idx_in   = 2'd0;
      end else if (pop) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bnd_ready && bnd_valid) bnd_ff <= bnd;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_out_kind        = bnd_ff.res[idx_ff].kind;
   assign rsp_out_char        = bnd_ff.res[idx_ff].ch;
   assign rsp_token_truncated = bnd_ff.res[idx_ff].trunc;
   assign rsp_run_last        = last;

endmodule

/* rtl/core/ttok_checker.sv */
// ttok_checker: port-level assertions for text_tokenizer_stream, plus bind.
// Depends on the top level's port list only.
module ttok_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_out_kind,
   input logic [7:0] rsp_out_char,
   input logic       rsp_token_truncated,
   input logic       rsp_run_last
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_kind) &&
         $stable(rsp_out_char) && $stable(rsp_token_truncated) && $stable(rsp_run_last))
      else $error("result word changed while stalled");

   // end marker carries no character
   a_end_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind |-> rsp_out_char == 8'd0)
      else $error("end marker with nonzero char");

   // truncation flag only on end markers
   a_trunc_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_kind |-> !rsp_token_truncated)
      else $error("truncation flag on a char word");

   // after reset both sides are empty and input is open
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

endmodule

bind text_tokenizer_stream ttok_checker u_ttok_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_out_kind        (rsp_out_kind),
   .rsp_out_char        (rsp_out_char),
   .rsp_token_truncated (rsp_token_truncated),
   .rsp_run_last        (rsp_run_last)
);
